>>> sv/zdscw_pkg.sv
// shared types and constants for the zoned disk sector chain writer
`default_nettype none
package zdscw_pkg;

   localparam int OFFSET_W     = 18;
   localparam int BYTE_W       = 8;
   localparam int TRACK_W      = 6;
   localparam int SIZE_W       = 13;
   localparam int SECTOR_W     = 5;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIZE_W-1:0] DATA_PER_SECTOR = 13'd254;
   localparam logic [BYTE_W-1:0] FIRST_DATA_BYTE = 8'd2;
   localparam logic [BYTE_W-1:0] WRAP_LINK_BYTE  = 8'd255;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic CSR_START_TRACK = 1'b0;
   localparam logic CSR_FILE_SIZE   = 1'b1;

   typedef struct packed {
      logic                has_data;
      logic [OFFSET_W-1:0] data_offset;
      logic [BYTE_W-1:0]   data_value;
      logic                has_link;
      logic [OFFSET_W-1:0] link_offset;
      logic [BYTE_W-1:0]   link_track_byte;
      logic [BYTE_W-1:0]   link_sector_byte;
      logic [SECTOR_W-1:0] blocks_used;
      logic                overflow;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] track_byte;
      logic [BYTE_W-1:0] sector_byte;
      logic              wrap;
   } link_type;

   // sectors per track by zone
   function automatic logic [SECTOR_W-1:0] zone_sectors(input logic [TRACK_W-1:0] t);
      logic [SECTOR_W-1:0] n;
      if (t <= 6'd17) begin
         n = 5'd21;
      end else if (t <= 6'd24) begin
         n = 5'd19;
      end else if (t <= 6'd30) begin
         n = 5'd18;
      end else begin
         n = 5'd17;
      end
      return n;
   endfunction

   // image offset of sector 0 of track t (t >= 1)
   function automatic logic [OFFSET_W-1:0] track_base(input logic [TRACK_W-1:0] t);
      logic [9:0] sectors;
      if (t <= 6'd18) begin
         sectors = 10'(t - 6'd1) * 10'd21;
      end else if (t <= 6'd25) begin
         sectors = 10'd357 + 10'(t - 6'd18) * 10'd19;
      end else if (t <= 6'd31) begin
         sectors = 10'd490 + 10'(t - 6'd25) * 10'd18;
      end else begin
         sectors = 10'd598 + 10'(t - 6'd31) * 10'd17;
      end
      return {sectors, 8'h00};
   endfunction

endpackage
`default_nettype wire

>>> sv/zdscw_front.sv
// front end: takes items, tracks the chain state and issues write commands
`default_nettype none
module zdscw_front #(
   parameter int INTERLEAVE  = 10,
   parameter int TRACK_COUNT = 35
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic [zdscw_pkg::TRACK_W-1:0] start_track,
   input  wire logic [zdscw_pkg::SIZE_W-1:0]  file_size,
   input  wire logic                          q_full,
   output logic                               q_push,
   output zdscw_pkg::cmd_type                 q_cmd
);
   import zdscw_pkg::*;

   logic [SECTOR_W-1:0] cur_ff, cur_in;
   logic [BYTE_W-1:0]   bis_ff, bis_in;
   logic [SIZE_W-1:0]   left_ff, left_in;
   logic [SECTOR_W-1:0] opened_ff, opened_in;
   logic [OFFSET_W-1:0] base_ff, base_in;
   logic [SECTOR_W-1:0] count_ff, count_in;
   logic [TRACK_W-1:0]  track_ff, track_in;
   logic                ovf_ff, ovf_in;

   function automatic logic [SECTOR_W-1:0] step_sector(input logic [SECTOR_W-1:0] a,
                                                       input logic [SECTOR_W-1:0] cnt);
      logic [SECTOR_W:0] s;
      s = {1'b0, a} + (SECTOR_W+1)'(INTERLEAVE);
      if (s >= {1'b0, cnt}) begin
         s = s - {1'b0, cnt};
      end
      return s[SECTOR_W-1:0];
   endfunction

   function automatic link_type make_link(input logic [SIZE_W-1:0]   left,
                                          input logic [SECTOR_W-1:0] sector,
                                          input logic [SECTOR_W-1:0] cnt,
                                          input logic [TRACK_W-1:0]  trk);
      logic [SECTOR_W-1:0] nx;
      link_type            l;
      nx = step_sector(sector, cnt);
      l  = '0;
      if (left <= DATA_PER_SECTOR) begin
         l.sector_byte = left[BYTE_W-1:0] + 8'd1;
      end else if (nx == '0) begin
         l.wrap        = 1'b1;
         l.sector_byte = WRAP_LINK_BYTE;
      end else begin
         l.track_byte  = {{(BYTE_W-TRACK_W){1'b0}}, trk};
         l.sector_byte = {{(BYTE_W-SECTOR_W){1'b0}}, nx};
      end
      return l;
   endfunction

   logic                accept;
   logic [TRACK_W-1:0]  t;
   logic [OFFSET_W-1:0] b;
   logic [SECTOR_W-1:0] zc;
   logic [SIZE_W-1:0]   left_n;
   logic [BYTE_W-1:0]   bis_n;
   logic [SECTOR_W-1:0] cur_n;
   link_type            lk;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      cur_in    = cur_ff;
      bis_in    = bis_ff;
      left_in   = left_ff;
      opened_in = opened_ff;
      base_in   = base_ff;
      count_in  = count_ff;
      track_in  = track_ff;
      ovf_in    = ovf_ff;
      q_push    = 1'b0;
      q_cmd     = '0;
      t         = start_track;
      if (start_track < 6'd1) begin
         t = 6'd1;
      end else if (start_track > TRACK_W'(TRACK_COUNT)) begin
         t = TRACK_W'(TRACK_COUNT);
      end
      b      = track_base(t);
      zc     = zone_sectors(t);
      left_n = left_ff - 13'd1;
      bis_n  = bis_ff + 8'd1;
      cur_n  = step_sector(cur_ff, count_ff);
      lk     = '0;
      if (accept) begin
         unique case (req_op)
            OP_START: begin
               lk        = make_link(file_size, '0, zc, t);
               track_in  = t;
               base_in   = b;
               count_in  = zc;
               cur_in    = '0;
               bis_in    = FIRST_DATA_BYTE;
               left_in   = file_size;
               opened_in = 5'd1;
               ovf_in    = lk.wrap;
               q_push    = 1'b1;
               q_cmd.has_link         = 1'b1;
               q_cmd.link_offset      = b;
               q_cmd.link_track_byte  = lk.track_byte;
               q_cmd.link_sector_byte = lk.sector_byte;
               q_cmd.blocks_used      = 5'd1;
               q_cmd.overflow         = lk.wrap;
            end
            OP_DATA: begin
               if (left_ff != '0) begin
                  left_in = left_n;
                  if (bis_ff != '0) begin
                     q_push            = 1'b1;
                     q_cmd.has_data    = 1'b1;
                     q_cmd.data_offset = base_ff + {5'b0, cur_ff, bis_ff};
                     q_cmd.data_value  = req_data_byte;
                     bis_in            = bis_n;
                     if (bis_n == '0 && left_n != '0 && !ovf_ff) begin
                        lk        = make_link(left_n, cur_n, count_ff, track_ff);
                        cur_in    = cur_n;
                        opened_in = opened_ff + 5'd1;
                        bis_in    = FIRST_DATA_BYTE;
                        ovf_in    = lk.wrap;
                        q_cmd.has_link         = 1'b1;
                        q_cmd.link_offset      = base_ff + {5'b0, cur_n, 8'h00};
                        q_cmd.link_track_byte  = lk.track_byte;
                        q_cmd.link_sector_byte = lk.sector_byte;
                     end
                     q_cmd.blocks_used = opened_in;
                     q_cmd.overflow    = ovf_in;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         bis_ff    <= '0;
         left_ff   <= '0;
         opened_ff <= '0;
         base_ff   <= '0;
         count_ff  <= 5'd21;
         track_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         cur_ff    <= cur_in;
         bis_ff    <= bis_in;
         left_ff   <= left_in;
         opened_ff <= opened_in;
         base_ff   <= base_in;
         count_ff  <= count_in;
         track_ff  <= track_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/zdscw_queue.sv
// short command queue between front and back ends
`default_nettype none
module zdscw_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire zdscw_pkg::cmd_type push_cmd,
   input  wire logic               pop,
   output zdscw_pkg::cmd_type      head_cmd,
   output logic                    full,
   output logic                    empty
);
   import zdscw_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/zdscw_back.sv
// back end: expands each command into image writes, one per cycle while rsp_stall is low
`default_nettype none
module zdscw_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_empty,
   input  wire zdscw_pkg::cmd_type             q_head,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [zdscw_pkg::OFFSET_W-1:0]      rsp_image_offset,
   output logic [zdscw_pkg::BYTE_W-1:0]        rsp_byte_value,
   output logic                                rsp_last,
   output logic [zdscw_pkg::SECTOR_W-1:0]      rsp_blocks_used,
   output logic                                rsp_overflow
);
   import zdscw_pkg::*;

   localparam logic [1:0] POS_DATA  = 2'd0;
   localparam logic [1:0] POS_LINK0 = 2'd1;
   localparam logic [1:0] POS_LINK1 = 2'd2;

   logic [1:0]          pos_ff, pos_in;
   logic [1:0]          pos;
   logic                valid_ff, valid_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0]   value_ff, value_in;
   logic                last_ff, last_in;
   logic [SECTOR_W-1:0] blocks_ff, blocks_in;
   logic                ovf_ff, ovf_in;
   logic                load;
   logic                piece_last;

   assign load = !valid_ff || !rsp_stall;
   assign pos  = (pos_ff == POS_DATA && !q_head.has_data) ? POS_LINK0 : pos_ff;
   assign piece_last = (pos == POS_DATA && !q_head.has_link) || (pos == POS_LINK1);

   always_comb begin
      pos_in    = pos_ff;
      valid_in  = valid_ff && rsp_stall;
      offset_in = offset_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      blocks_in = blocks_ff;
      ovf_in    = ovf_ff;
      q_pop     = 1'b0;
      if (load && !q_empty) begin
         valid_in  = 1'b1;
         last_in   = piece_last;
         blocks_in = q_head.blocks_used;
         ovf_in    = q_head.overflow;
         unique case (pos)
            POS_DATA: begin
               offset_in = q_head.data_offset;
               value_in  = q_head.data_value;
            end
            POS_LINK0: begin
               offset_in = q_head.link_offset;
               value_in  = q_head.link_track_byte;
            end
            POS_LINK1: begin
               offset_in = q_head.link_offset + 18'd1;
               value_in  = q_head.link_sector_byte;
            end
            default: begin
               offset_in = q_head.link_offset;
               value_in  = q_head.link_track_byte;
            end
         endcase
         if (piece_last) begin
            q_pop  = 1'b1;
            pos_in = POS_DATA;
         end else begin
            pos_in = pos + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_DATA;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
      blocks_ff <= blocks_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_image_offset = offset_ff;
   assign rsp_byte_value   = value_ff;
   assign rsp_last         = last_ff;
   assign rsp_blocks_used  = blocks_ff;
   assign rsp_overflow     = ovf_ff;

endmodule
`default_nettype wire

>>> sv/zoned_disk_sector_chain_writer.sv
// top level of the zoned disk sector chain writer
// Lays a file out on one track of a zoned disk image as a chain of 256-byte sectors and
// emits one image write per rsp transaction. The front end takes one req transaction per
// cycle while the queue has room and pushes commands into a four-entry queue; the back end
// turns each command into one to three writes, one per cycle while rsp_stall is low, through
// a single registered result port: one for a data byte, three for a byte that fills a sector
// and opens the next, two for a start. Writes go through the queue and the result register.
// Configuration is written with csr_write, csr_index and csr_wdata while the block is idle;
// start_track and file_size are taken at the start item.
`default_nettype none
module zoned_disk_sector_chain_writer #(
   parameter int INTERLEAVE  = 10,
   parameter int TRACK_COUNT = 35
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_op,
   input  wire logic [7:0]                      req_data_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [zdscw_pkg::OFFSET_W-1:0]       rsp_image_offset,
   output logic [zdscw_pkg::BYTE_W-1:0]         rsp_byte_value,
   output logic                                 rsp_last,
   output logic [zdscw_pkg::SECTOR_W-1:0]       rsp_blocks_used,
   output logic                                 rsp_overflow,
   input  wire logic                            csr_write,
   input  wire logic                            csr_index,
   input  wire logic [zdscw_pkg::SIZE_W-1:0]    csr_wdata
);
   import zdscw_pkg::*;

   logic [TRACK_W-1:0] start_track_ff, start_track_in;
   logic [SIZE_W-1:0]  file_size_ff, file_size_in;
   logic               q_full, q_empty, q_push, q_pop;
   cmd_type            push_cmd, head_cmd;

   always_comb begin
      start_track_in = start_track_ff;
      file_size_in   = file_size_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_START_TRACK: start_track_in = csr_wdata[TRACK_W-1:0];
            CSR_FILE_SIZE:   file_size_in   = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_track_ff <= 6'd14;
         file_size_ff   <= '0;
      end else begin
         start_track_ff <= start_track_in;
         file_size_ff   <= file_size_in;
      end
   end

   zdscw_front #(
      .INTERLEAVE  (INTERLEAVE),
      .TRACK_COUNT (TRACK_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .start_track   (start_track_ff),
      .file_size     (file_size_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   zdscw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   zdscw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_image_offset (rsp_image_offset),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last         (rsp_last),
      .rsp_blocks_used  (rsp_blocks_used),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
`default_nettype wire

>>> tb/zdscw_write_checker.sv
// checker for the sector chain writer: mirrors the registers, predicts image writes, compares
`timescale 1ns / 100ps
module zdscw_write_checker
   import zdscw_pkg::*;
#(
   parameter int INTERLEAVE  = 10,
   parameter int TRACK_COUNT = 35
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_op,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [OFFSET_W-1:0] rsp_image_offset,
   input  logic [BYTE_W-1:0]   rsp_byte_value,
   input  logic                rsp_last,
   input  logic [SECTOR_W-1:0] rsp_blocks_used,
   input  logic                rsp_overflow,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [SIZE_W-1:0]   csr_wdata,
   output int                  mismatches,
   output int                  pending
);

   localparam int SECTOR_BYTES = 256;

   typedef struct packed {
      logic [OFFSET_W-1:0] image_offset;
      logic [BYTE_W-1:0]   byte_value;
      logic                last;
      logic [SECTOR_W-1:0] blocks_used;
      logic                overflow;
   } image_write_t;

   image_write_t writes_due[$];
   image_write_t new_writes[$];

   logic [TRACK_W-1:0]  reg_track;
   logic [SIZE_W-1:0]   reg_size;
   logic [SECTOR_W-1:0] cur_sector;
   logic [BYTE_W-1:0]   sector_pos;
   logic [SIZE_W-1:0]   bytes_left;
   logic [SECTOR_W-1:0] opened;
   logic [OFFSET_W-1:0] base_offset;
   logic [SECTOR_W-1:0] zone_count;
   logic [TRACK_W-1:0]  file_track;
   logic                chain_full;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic int sectors_on(input int trk);
      if (trk <= 17) begin
         return 21;
      end else if (trk <= 24) begin
         return 19;
      end else if (trk <= 30) begin
         return 18;
      end
      return 17;
   endfunction

   task automatic add_write(input int offset, input int value);
      image_write_t w;
      w = '0;
      w.image_offset = offset[OFFSET_W-1:0];
      w.byte_value   = value[BYTE_W-1:0];
      new_writes.push_back(w);
   endtask

   // two link bytes at the head of the current sector
   task automatic add_link_bytes();
      int at;
      int nx;
      at = base_offset + cur_sector * SECTOR_BYTES;
      if (bytes_left <= DATA_PER_SECTOR) begin
         add_write(at, 0);
         add_write(at + 1, bytes_left + 1);
      end else begin
         nx = (cur_sector + INTERLEAVE) % zone_count;
         if (nx == 0) begin
            chain_full = 1'b1;
            add_write(at, 0);
            add_write(at + 1, WRAP_LINK_BYTE);
         end else begin
            add_write(at, file_track);
            add_write(at + 1, nx);
         end
      end
   endtask

   task automatic predict_writes(input logic op, input logic [BYTE_W-1:0] value);
      int trk;
      int base;
      int i;
      image_write_t w;
      if (op == OP_START) begin
         trk = reg_track;
         if (trk < 1) trk = 1;
         if (trk > TRACK_COUNT) trk = TRACK_COUNT;
         base = 0;
         for (i = 1; i < trk; i++) base += sectors_on(i) * SECTOR_BYTES;
         file_track  = trk[TRACK_W-1:0];
         base_offset = base[OFFSET_W-1:0];
         zone_count  = SECTOR_W'(sectors_on(trk));
         cur_sector  = '0;
         sector_pos  = FIRST_DATA_BYTE;
         bytes_left  = reg_size;
         opened      = SECTOR_W'(1);
         chain_full  = 1'b0;
         add_link_bytes();
      end else if (bytes_left != 0) begin
         if (sector_pos == 0) begin
            bytes_left--;
         end else begin
            add_write(base_offset + cur_sector * SECTOR_BYTES + sector_pos, value);
            bytes_left--;
            sector_pos++;
            if (sector_pos == 0 && bytes_left != 0 && !chain_full) begin
               cur_sector = SECTOR_W'((cur_sector + INTERLEAVE) % zone_count);
               opened++;
               sector_pos = FIRST_DATA_BYTE;
               add_link_bytes();
            end
         end
      end
      for (i = 0; i < new_writes.size(); i++) begin
         w = new_writes[i];
         w.last        = (i == new_writes.size() - 1);
         w.blocks_used = opened;
         w.overflow    = chain_full;
         writes_due.push_back(w);
      end
      new_writes.delete();
   endtask

   task automatic compare_field(input string field, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      image_write_t want;
      if (reset) begin
         reg_track   = 6'd14;
         reg_size    = '0;
         cur_sector  = '0;
         sector_pos  = '0;
         bytes_left  = '0;
         opened      = '0;
         base_offset = '0;
         zone_count  = 5'd21;
         file_track  = '0;
         chain_full  = 1'b0;
         writes_due.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_START_TRACK) begin
               reg_track = csr_wdata[TRACK_W-1:0];
            end else begin
               reg_size = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (writes_due.size() == 0) begin
               $error("image write at offset %0d with none expected", rsp_image_offset);
               mismatches++;
            end else begin
               want = writes_due.pop_front();
               compare_field("image_offset", want.image_offset, rsp_image_offset);
               compare_field("byte_value", want.byte_value, rsp_byte_value);
               compare_field("last", want.last, rsp_last);
               compare_field("blocks_used", want.blocks_used, rsp_blocks_used);
               compare_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && !req_stall) predict_writes(req_op, req_data_byte);
      end
      pending <= writes_due.size();
   end

endmodule

>>> tb/tb.sv
// testbench top for the sector chain writer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
   import zdscw_pkg::*;

   localparam int INTERLEAVE  = 10;
   localparam int TRACK_COUNT = 35;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_op;
   logic [7:0]          req_data_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [OFFSET_W-1:0] rsp_image_offset;
   logic [BYTE_W-1:0]   rsp_byte_value;
   logic                rsp_last;
   logic [SECTOR_W-1:0] rsp_blocks_used;
   logic                rsp_overflow;
   logic                csr_write;
   logic                csr_index;
   logic [SIZE_W-1:0]   csr_wdata;

   int mismatches;
   int pending;
   int cycles = 0;
   int items_sent = 0;
   bit calm = 1'b0;
   bit held = 1'b0;

   zoned_disk_sector_chain_writer #(
      .INTERLEAVE  (INTERLEAVE),
      .TRACK_COUNT (TRACK_COUNT)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_image_offset (rsp_image_offset),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last         (rsp_last),
      .rsp_blocks_used  (rsp_blocks_used),
      .rsp_overflow     (rsp_overflow),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   zdscw_write_checker #(
      .INTERLEAVE  (INTERLEAVE),
      .TRACK_COUNT (TRACK_COUNT)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_image_offset (rsp_image_offset),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last         (rsp_last),
      .rsp_blocks_used  (rsp_blocks_used),
      .rsp_overflow     (rsp_overflow),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("zoned_disk_sector_chain_writer: mismatch");
         $finish;
      end
   end

   task automatic put_transaction(input logic op, input logic [7:0] value);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // hold the sender until every outstanding write has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_regs(input int track, input int size);
      csr_write <= 1'b1;
      csr_index <= CSR_START_TRACK;
      csr_wdata <= SIZE_W'(track);
      @(posedge clock);
      csr_index <= CSR_FILE_SIZE;
      csr_wdata <= SIZE_W'(size);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_file(input int track, input int size, input bit breakable);
      int cut;
      int k;
      drain();
      set_regs(track, size);
      cut = (breakable && $urandom_range(0, 9) == 0) ? $urandom_range(0, size) : -1;
      put_transaction(OP_START, 8'($urandom));
      items_sent++;
      for (k = 0; k < size; k++) begin
         if (k == cut) begin
            // restart the chain part way through
            put_transaction(OP_START, 8'($urandom));
            items_sent++;
            cut = -1;
            k = -1;
            continue;
         end
         if (!held && size > 40 && k == size / 2) begin
            drain();
            held = 1'b1;
         end
         put_transaction(OP_DATA, 8'($urandom_range(0, 255)));
         items_sent++;
      end
      repeat ($urandom_range(0, 2)) put_transaction(OP_DATA, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int files;
      int track;
      int size;
      int pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_START;
      req_data_byte = '0;
      rsp_stall     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CSR_START_TRACK;
      csr_wdata     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values, then a byte with no file open
      put_transaction(OP_START, 8'h00);
      put_transaction(OP_DATA, 8'hA5);

      drain();
      set_regs(0, 1);
      put_transaction(OP_START, 8'h00);
      put_transaction(OP_DATA, 8'hFF);
      put_transaction(OP_DATA, 8'h00);

      drain();
      set_regs(63, 3);
      put_transaction(OP_START, 8'hFF);
      put_transaction(OP_DATA, 8'h00);
      put_transaction(OP_START, 8'h00);
      put_transaction(OP_DATA, 8'hFF);
      put_transaction(OP_DATA, 8'h55);
      put_transaction(OP_DATA, 8'hAA);

      drain();
      set_regs(18, 2);
      put_transaction(OP_START, 8'h12);
      put_transaction(OP_DATA, 8'h80);
      put_transaction(OP_DATA, 8'h7F);

      drain();
      set_regs(25, 0);
      put_transaction(OP_START, 8'h00);
      put_transaction(OP_START, 8'hFF);
      put_transaction(OP_DATA, 8'h01);
      put_transaction(OP_DATA, 8'hFE);

      items_sent = 0;
      files = 0;
      while (items_sent < 120 || files < 3) begin
         if ($urandom_range(0, 3) == 0) begin
            track = $urandom_range(0, 63);
         end else begin
            track = $urandom_range(1, TRACK_COUNT);
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            size = $urandom_range(0, 16);
         end else if (pick < 8) begin
            size = $urandom_range(240, 270);
         end else begin
            size = $urandom_range(0, 60);
         end
         write_file(track, size, 1'b1);
         files++;
      end

      // one file across a sector boundary with no idling on either side
      calm = 1'b1;
      write_file($urandom_range(1, TRACK_COUNT), 260, 1'b0);
      calm = 1'b0;

      drain();
      if (mismatches == 0) begin
         $display("zoned_disk_sector_chain_writer: match");
      end else begin
         $display("zoned_disk_sector_chain_writer: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/zdscw_pkg.sv
sv/zdscw_front.sv
sv/zdscw_queue.sv
sv/zdscw_back.sv
sv/zoned_disk_sector_chain_writer.sv
tb/zdscw_write_checker.sv
tb/tb.sv
